// File: rtl/mcud_pkg.sv
// Shared widths, codes and cell control types for the urgent deque block.
package mcud_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_QUEUES_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned TAG_BITS_DEF    = 16;

  // Fixed port field widths
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned QSEL_W   = 5;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 4;
  localparam int unsigned MW_W     = 4;

  localparam logic [MW_W-1:0] RESET_MAX_WAITING = MW_W'(5);

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TAKE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // How the slot cells move data on a write cycle
  typedef enum logic [1:0] {
    MODE_PUSH_FRONT,
    MODE_PUSH_BACK,
    MODE_POP_FRONT
  } shift_mode_e;

  typedef struct packed {
    logic        we;
    shift_mode_e mode;
  } cell_ctrl_t;

endpackage

// File: rtl/mcud_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcud_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mcud_cell.sv
// One slot cell: holds slot IDX of every queue and shifts with its neighbors.
module mcud_cell
  import mcud_pkg::*;
#(
  parameter int unsigned NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int unsigned EW         = TAG_BITS_DEF + 1,
  parameter int unsigned CW         = 4,
  parameter int unsigned IDX        = 0,
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [QW-1:0] rd_addr_i,
  input  logic [QW-1:0] wr_addr_i,
  input  cell_ctrl_t    ctrl_i,
  input  logic [CW-1:0] count_i,
  input  logic [EW-1:0] left_i,   // slot IDX-1 of the addressed queue (new entry at slot 0)
  input  logic [EW-1:0] right_i,  // slot IDX+1 of the addressed queue (own slot at the last cell)
  input  logic [EW-1:0] new_i,
  output logic [EW-1:0] data_o
);

  logic          we;
  logic [EW-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    wdata = left_i;
    unique case (ctrl_i.mode)
      MODE_PUSH_FRONT: begin
        we    = ctrl_i.we;
        wdata = left_i;
      end
      MODE_PUSH_BACK: begin
        we    = ctrl_i.we && (count_i == CW'(IDX));
        wdata = new_i;
      end
      MODE_POP_FRONT: begin
        we    = ctrl_i.we;
        wdata = right_i;
      end
      default: begin
        we    = 1'b0;
        wdata = left_i;
      end
    endcase
  end

  mcud_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_QUEUES)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_addr_i),
    .wdata_i (wdata),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (data_o)
  );

endmodule

// File: rtl/multi_class_urgent_deque_core.sv
// Top level: NUM_QUEUES bounded deques with urgent front insert, built as a row of slot cells.
//
// Usage:
//   Commands enter on the in_* channel (valid/ready). An add places entry_tag
//   at the back of queue queue_sel, or at the front when urgent is set; it is
//   refused with status "full" once the queue holds min(max_waiting,
//   QUEUE_DEPTH) entries. A take pops the front entry or reports "empty".
//   Every command yields exactly one result transfer on the out_* channel with
//   the queue's occupancy after the operation. Out-of-range queue indices
//   change nothing and answer full/empty with occupancy 0.
// Timing:
//   Transfer cycle reads the count RAM and every slot cell RAM at queue_sel.
//   Next cycle computes the result; on commit it shifts the cells (one write
//   per cell RAM) and loads the output register. A new command is taken only
//   after the previous one commits, set by the registered RAM read followed
//   by the shift write of the same queue.
// Stall: while a result waits, the next command is still taken and read; it
//   holds in the execute state until the output register frees.
// Reset: all queues read empty (per-queue valid bits, no clearing pass);
//   max_waiting returns to 5. max_waiting is written via cfg_we_i/cfg_wdata_i.
module multi_class_urgent_deque_core
  import mcud_pkg::*;
#(
  parameter int unsigned NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [MW_W-1:0]     cfg_wdata_i,
  // command channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [QSEL_W-1:0]   queue_sel_i,
  input  logic [TAG_W-1:0]    entry_tag_i,
  input  logic                urgent_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [TAG_W-1:0]    taken_tag_o,
  output logic                taken_urgent_o,
  output logic [OCC_W-1:0]    occupancy_o
);

  localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned EXT_W = ((QW > QSEL_W) ? QW : QSEL_W) + 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CW > MW_W) ? CW : MW_W;
  localparam int unsigned EW    = TAG_BITS + 1;   // {urgent, tag}

  // sequencer states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic accept, commit;

  // captured command
  logic [CMD_W-1:0]    cmd_q;
  logic [QW-1:0]       addr_q;
  logic                in_range_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                urg_q;

  logic [EXT_W-1:0] sel_ext;
  logic [QW-1:0]    sel_addr;
  logic             sel_in_range;

  // config
  logic [MW_W-1:0] max_waiting_q;

  // per-queue count storage
  logic [NUM_QUEUES-1:0] cnt_vld_q, cnt_vld_d;
  logic [CW-1:0]         cnt_rdata, n_cur, n_new;
  logic                  cnt_we;

  // cell row
  cell_ctrl_t    cell_ctrl;
  logic [EW-1:0] new_entry;
  logic [EW-1:0] cell_data [QUEUE_DEPTH];

  // capacity check
  logic [CMP_W-1:0] mw_ext, depth_c, cap;
  logic             full;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [TAG_BITS-1:0] ttag_q, ttag_d;
  logic                turg_q, turg_d;
  logic [CW-1:0]       occ_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign sel_ext      = EXT_W'(queue_sel_i);
  assign sel_addr     = sel_ext[QW-1:0];
  assign sel_in_range = sel_ext < EXT_W'(NUM_QUEUES);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      max_waiting_q <= RESET_MAX_WAITING;
      cnt_vld_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_vld_q   <= cnt_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_waiting_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_i;
      addr_q     <= sel_addr;
      in_range_q <= sel_in_range;
      tag_q      <= TAG_BITS'(entry_tag_i);
      urg_q      <= urgent_i;
    end
    if (commit) begin
      status_q <= status_d;
      ttag_q   <= ttag_d;
      turg_q   <= turg_d;
      occ_q    <= n_new;
    end
  end

  // count RAM; a queue never written reads as empty
  mcud_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_QUEUES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (addr_q),
    .wdata_i (n_new),
    .re_i    (accept),
    .raddr_i (sel_addr),
    .rdata_o (cnt_rdata)
  );

  assign n_cur = cnt_vld_q[addr_q] ? cnt_rdata : '0;

  always_comb begin
    cnt_vld_d = cnt_vld_q;
    if (cnt_we) begin
      cnt_vld_d[addr_q] = 1'b1;
    end
  end

  assign mw_ext  = CMP_W'(max_waiting_q);
  assign depth_c = CMP_W'(QUEUE_DEPTH);
  assign cap     = (mw_ext < depth_c) ? mw_ext : depth_c;
  assign full    = CMP_W'(n_cur) >= cap;

  assign new_entry = {urg_q, tag_q};

  // command decode and result
  always_comb begin
    status_d       = ST_FULL;
    ttag_d         = '0;
    turg_d         = 1'b0;
    n_new          = n_cur;
    cnt_we         = 1'b0;
    cell_ctrl.we   = 1'b0;
    cell_ctrl.mode = MODE_PUSH_BACK;
    priority if (!in_range_q) begin
      status_d = (cmd_q == CMD_TAKE) ? ST_EMPTY : ST_FULL;
      n_new    = '0;
    end else if (cmd_q == CMD_ADD) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        status_d       = ST_ADDED;
        n_new          = n_cur + CW'(1);
        cnt_we         = commit;
        cell_ctrl.we   = commit;
        cell_ctrl.mode = urg_q ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      end
    end else begin
      if (n_cur == '0) begin
        status_d = ST_EMPTY;
      end else begin
        status_d       = ST_TAKEN;
        ttag_d         = cell_data[0][TAG_BITS-1:0];
        turg_d         = cell_data[0][TAG_BITS];
        n_new          = n_cur - CW'(1);
        cnt_we         = commit;
        cell_ctrl.we   = commit;
        cell_ctrl.mode = MODE_POP_FRONT;
      end
    end
  end

  // row of slot cells; cell k holds slot k of every queue
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [EW-1:0] left_data, right_data;
    if (k == 0) begin : g_first
      assign left_data = new_entry;
    end else begin : g_mid_l
      assign left_data = cell_data[k-1];
    end
    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign right_data = cell_data[k];
    end else begin : g_mid_r
      assign right_data = cell_data[k+1];
    end

    mcud_cell #(
      .NUM_QUEUES (NUM_QUEUES),
      .EW         (EW),
      .CW         (CW),
      .IDX        (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rd_en_i   (accept),
      .rd_addr_i (sel_addr),
      .wr_addr_i (addr_q),
      .ctrl_i    (cell_ctrl),
      .count_i   (n_cur),
      .left_i    (left_data),
      .right_i   (right_data),
      .new_i     (new_entry),
      .data_o    (cell_data[k])
    );
  end

  // output register: load on commit, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign taken_tag_o    = TAG_W'(ttag_q);
  assign taken_urgent_o = turg_q;
  assign occupancy_o    = OCC_W'(occ_q);

  // checks
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("command transfer did not start execution");

  a_commit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("commit did not present a result");

  a_stall_holds_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && out_valid_q && !out_ready_i) |=> (state_q == S_EXEC))
    else $error("command left execution while output was blocked");

  a_no_write_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && !in_range_q) |-> (!cnt_we && !cell_ctrl.we))
    else $error("out-of-range queue modified state");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (CMP_W'(n_new) <= depth_c))
    else $error("queue count above depth");

endmodule

// File: sim/deque_result_check.sv
// Checker for the urgent deque block: tracks the queues, predicts each result and compares.
module deque_result_check
  import mcud_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MW_W-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [QSEL_W-1:0]   queue_sel_i,
  input  logic [TAG_W-1:0]    entry_tag_i,
  input  logic                urgent_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [TAG_W-1:0]    taken_tag_i,
  input  logic                taken_urgent_i,
  input  logic [OCC_W-1:0]    occupancy_i,
  output int unsigned         mismatches_o,
  output int unsigned         outstanding_o
);

  localparam int unsigned NQ = NUM_QUEUES_DEF;
  localparam int unsigned QD = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic                urg;
    logic [OCC_W-1:0]    occ;
  } deque_result_t;

  logic [TAG_W-1:0] slot_tag [NQ][QD];
  logic             slot_urg [NQ][QD];
  int unsigned      fill [NQ];
  logic [MW_W-1:0]  max_waiting;

  deque_result_t    result_fifo [$];
  deque_result_t    want;

  // Applies one command to the shadow queues and returns its result.
  function automatic deque_result_t apply_cmd(logic [CMD_W-1:0] c, logic [QSEL_W-1:0] q,
                                              logic [TAG_W-1:0] t, logic u);
    deque_result_t r;
    int unsigned   n;
    int unsigned   lim;
    r = '0;
    if (q >= NQ) begin
      r.status = (c == CMD_TAKE) ? ST_EMPTY : ST_FULL;
      return r;
    end
    n   = fill[q];
    lim = (max_waiting < QD) ? max_waiting : QD;
    if (c == CMD_ADD) begin
      if (n >= lim) begin
        r.status = ST_FULL;
      end else begin
        if (u) begin
          for (int j = n; j > 0; j--) begin
            slot_tag[q][j] = slot_tag[q][j-1];
            slot_urg[q][j] = slot_urg[q][j-1];
          end
          slot_tag[q][0] = t;
          slot_urg[q][0] = 1'b1;
        end else begin
          slot_tag[q][n] = t;
          slot_urg[q][n] = 1'b0;
        end
        n++;
        r.status = ST_ADDED;
      end
    end else if (n == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.tag = slot_tag[q][0];
      r.urg = slot_urg[q][0];
      n--;
      for (int j = 0; j < n; j++) begin
        slot_tag[q][j] = slot_tag[q][j+1];
        slot_urg[q][j] = slot_urg[q][j+1];
      end
      r.status = ST_TAKEN;
    end
    fill[q] = n;
    r.occ   = OCC_W'(n);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NQ; k++) fill[k] = 0;
      max_waiting   = RESET_MAX_WAITING;
      result_fifo.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) max_waiting = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result: status %0d tag %h urgent %0d occupancy %0d",
                   $time, status_i, taken_tag_i, taken_urgent_i, occupancy_i);
          mismatches_o++;
        end else begin
          want = result_fifo.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_i);
            mismatches_o++;
          end
          if (taken_tag_i !== want.tag) begin
            $display("%0t: taken_tag expected %h, got %h", $time, want.tag, taken_tag_i);
            mismatches_o++;
          end
          if (taken_urgent_i !== want.urg) begin
            $display("%0t: taken_urgent expected %0d, got %0d",
                     $time, want.urg, taken_urgent_i);
            mismatches_o++;
          end
          if (occupancy_i !== want.occ) begin
            $display("%0t: occupancy expected %0d, got %0d", $time, want.occ, occupancy_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        result_fifo.push_back(apply_cmd(cmd_i, queue_sel_i, entry_tag_i, urgent_i));
      outstanding_o = result_fifo.size();
    end
  end

endmodule

// File: sim/tb.sv
// Testbench top: drives commands and result back-pressure into the urgent deque block.
module tb;
  import mcud_pkg::*;

  // Limit per random phase; covers zero capacity, capacity above depth and
  // limits dropped below what a queue already holds.
  localparam logic [MW_W-1:0] PHASE_LIMITS [8] = '{4'd1, 4'd8, 4'd3, 4'd15,
                                                   4'd0, 4'd6, 4'd2, 4'd8};
  localparam int PHASE_ITEMS = 85;
  localparam int HOLD_CYCLES = 50;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [MW_W-1:0]     cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd          = CMD_ADD;
  logic [QSEL_W-1:0]   queue_sel    = '0;
  logic [TAG_W-1:0]    entry_tag    = '0;
  logic                urgent       = 1'b0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    taken_tag;
  logic                taken_urgent;
  logic [OCC_W-1:0]    occupancy;

  int unsigned         mismatches;
  int unsigned         outstanding;

  bit                  idle_on  = 1'b1;   // random gaps on both channels
  bit                  hold_req = 1'b0;   // asks the receiver for one long stall

  multi_class_urgent_deque_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .queue_sel_i    (queue_sel),
    .entry_tag_i    (entry_tag),
    .urgent_i       (urgent),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .taken_tag_o    (taken_tag),
    .taken_urgent_o (taken_urgent),
    .occupancy_o    (occupancy)
  );

  deque_result_check checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .queue_sel_i    (queue_sel),
    .entry_tag_i    (entry_tag),
    .urgent_i       (urgent),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .taken_tag_i    (taken_tag),
    .taken_urgent_i (taken_urgent),
    .occupancy_i    (occupancy),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // Watchdog: reports failure and stops the run if the stimulus never finishes.
  initial begin : watchdog
    #400000;
    $display("tb: failure");
    $finish;
  end

  // Result side. Normally ready; random short stalls while idling is on, and
  // one long stall on request so the block backs up into its input.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One command transfer. Returns right after the accepting edge with valid
  // still high, so back-to-back commands keep valid up.
  task automatic send_cmd(logic [CMD_W-1:0] c, logic [QSEL_W-1:0] q,
                          logic [TAG_W-1:0] t, logic u);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    cmd       <= c;
    queue_sel <= q;
    entry_tag <= t;
    urgent    <= u;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every expected result has been transferred.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Limit writes happen only with the block idle.
  task automatic set_limit(logic [MW_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [QSEL_W-1:0] hot [3];
    logic [QSEL_W-1:0] q;
    logic [CMD_W-1:0]  c;
    int                add_pct;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset limit of 5: take from empty, urgent jumps ahead of
    // regular entries, extreme tags.
    send_cmd(CMD_TAKE, 5'd0, 16'h0000, 1'b1);
    send_cmd(CMD_ADD,  5'd0, 16'hFFFF, 1'b0);
    send_cmd(CMD_ADD,  5'd0, 16'h0000, 1'b1);
    send_cmd(CMD_ADD,  5'd0, 16'h1234, 1'b0);
    repeat (3) send_cmd(CMD_TAKE, 5'd0, 16'hFFFF, 1'b0);
    // Top queue up to the reset limit; the sixth add must come back full.
    for (int k = 0; k < 6; k++) send_cmd(CMD_ADD, 5'd31, TAG_W'(16'hA500 + k), k[0]);
    // Zero capacity: add refused, take on an empty queue.
    set_limit(4'd0);
    send_cmd(CMD_ADD,  5'd5, 16'h5A5A, 1'b0);
    send_cmd(CMD_TAKE, 5'd5, 16'h0000, 1'b0);
    // Limit above depth: capacity stops at depth, occupancy reaches 8.
    set_limit(4'd15);
    for (int k = 0; k < 9; k++) send_cmd(CMD_ADD, 5'd1, TAG_W'(16'hC000 | k), k == 4);

    // Random phases. Most commands hit a few hot queues so they fill to the
    // limit and drain to empty; the rest spread over all queues.
    for (int p = 0; p < 8; p++) begin
      set_limit(PHASE_LIMITS[p]);
      idle_on = (p != 7);      // last phase runs at full rate
      for (int k = 0; k < 3; k++) hot[k] = QSEL_W'($urandom_range(0, 31));
      add_pct = $urandom_range(35, 70);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 20) hold_req = 1'b1;   // back-pressure until input stalls
        if (p == 4 && i == 40) drain();           // sender pause mid-phase
        q = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 2)]
                                       : QSEL_W'($urandom_range(0, 31));
        c = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_TAKE;
        send_cmd(c, q, TAG_W'($urandom), $urandom_range(0, 9) < 4);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
